/* src/ercf_pkg.sv */
// shared types, codes and activation functions of the recurrent cell forward pass
// no dependencies
`default_nettype none

package ercf_pkg;

  localparam int DataW    = 16;
  localparam int SumW     = 24;
  localparam int PW       = 29;
  localparam int BW       = 17;
  localparam int VW       = 20;
  localparam int LW       = 18;
  localparam int TW       = 14;
  localparam int SW       = 13;
  localparam int ArgW     = 30;
  localparam int CntW     = 8;
  localparam int SlopeW   = 12;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 64;
  localparam int OpW      = 5;

  localparam logic [CfgIdxW-1:0] REG_IPS   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_WF    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_WM    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_WB    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SLOPE = 3'd4;

  localparam logic [OpW-1:0] OP_NOP    = 5'd0;
  localparam logic [OpW-1:0] OP_ACC    = 5'd1;
  localparam logic [OpW-1:0] OP_M_XZ   = 5'd2;
  localparam logic [OpW-1:0] OP_M_HR   = 5'd3;
  localparam logic [OpW-1:0] OP_T_Z    = 5'd4;
  localparam logic [OpW-1:0] OP_M_W1   = 5'd5;
  localparam logic [OpW-1:0] OP_T_T1   = 5'd6;
  localparam logic [OpW-1:0] OP_M_W6   = 5'd7;
  localparam logic [OpW-1:0] OP_SIG    = 5'd8;
  localparam logic [OpW-1:0] OP_MUL_VS = 5'd9;
  localparam logic [OpW-1:0] OP_M_W2   = 5'd10;
  localparam logic [OpW-1:0] OP_T_T2   = 5'd11;
  localparam logic [OpW-1:0] OP_M_W3   = 5'd12;
  localparam logic [OpW-1:0] OP_LK     = 5'd13;
  localparam logic [OpW-1:0] OP_LK_L3  = 5'd14;
  localparam logic [OpW-1:0] OP_M_W4   = 5'd15;
  localparam logic [OpW-1:0] OP_LK_SUM = 5'd16;
  localparam logic [OpW-1:0] OP_M_W5   = 5'd17;
  localparam logic [OpW-1:0] OP_M_W7   = 5'd18;
  localparam logic [OpW-1:0] OP_T_B7   = 5'd19;
  localparam logic [OpW-1:0] OP_M_W8   = 5'd20;
  localparam logic [OpW-1:0] OP_FIN    = 5'd21;

  typedef struct packed {
    logic [OpW-1:0] op;
  } ercf_cmd_t;

  typedef struct packed {
    logic complete;
    logic out_hold;
  } ercf_status_t;

  localparam logic [ArgW-1:0] TanhLimit = 30'd20480;
  localparam logic [SW-1:0] QOne = 13'd4096;
  localparam logic [SW-1:0] TANH_LUT [11] = '{
    13'd0, 13'd1893, 13'd3119, 13'd3707, 13'd3949, 13'd4041,
    13'd4076, 13'd4089, 13'd4093, 13'd4095, 13'd4096
  };

  function automatic logic [SW-1:0] tanh_mag(input logic [ArgW-1:0] a);
    logic [3:0] idx;
    logic [10:0] frac;
    logic [SW-1:0] lo;
    logic [SW-1:0] hi;
    logic [10:0] d;
    logic [21:0] pr;
    idx  = a[14:11];
    frac = a[10:0];
    lo   = TANH_LUT[idx];
    hi   = TANH_LUT[4'(idx + 4'd1)];
    d    = 11'(hi - lo);
    pr   = {11'b0, d} * {11'b0, frac};
    if (a >= TanhLimit) begin
      return QOne;
    end
    return lo + SW'(pr[21:11]);
  endfunction

  function automatic logic signed [TW-1:0] act_tanh(input logic signed [ArgW-1:0] v);
    logic [ArgW-1:0] m;
    logic [TW-1:0] mag;
    m   = v[ArgW-1] ? ArgW'(-v) : v;
    mag = {1'b0, tanh_mag(m)};
    return v[ArgW-1] ? TW'(-mag) : mag;
  endfunction

  function automatic logic [SW-1:0] sigmoid(input logic signed [ArgW-1:0] v);
    logic [ArgW-1:0] m;
    logic [SW:0] t;
    logic [SW-1:0] s;
    m = v[ArgW-1] ? ArgW'(-v) : v;
    t = 14'd4096 + {1'b0, tanh_mag(m >> 1)};
    s = t[SW:1];
    return v[ArgW-1] ? QOne - s : s;
  endfunction

endpackage

`default_nettype wire

/* src/ercf_ctrl.sv */
// controller state machine: sequences the shared multiplier and activations
// depends on ercf_pkg
`default_nettype none

module ercf_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire ercf_pkg::ercf_status_t status,
  output ercf_pkg::ercf_cmd_t        cmd,
  output logic                       in_stall
);
  import ercf_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_XZ   = 5'd1;
  localparam logic [4:0] S_HR   = 5'd2;
  localparam logic [4:0] S_TZ   = 5'd3;
  localparam logic [4:0] S_W1   = 5'd4;
  localparam logic [4:0] S_TT1  = 5'd5;
  localparam logic [4:0] S_W6   = 5'd6;
  localparam logic [4:0] S_SG6  = 5'd7;
  localparam logic [4:0] S_MS6  = 5'd8;
  localparam logic [4:0] S_W2   = 5'd9;
  localparam logic [4:0] S_TT2  = 5'd10;
  localparam logic [4:0] S_W3   = 5'd11;
  localparam logic [4:0] S_LK3  = 5'd12;
  localparam logic [4:0] S_LD3  = 5'd13;
  localparam logic [4:0] S_W4   = 5'd14;
  localparam logic [4:0] S_LK4  = 5'd15;
  localparam logic [4:0] S_LD4  = 5'd16;
  localparam logic [4:0] S_W5   = 5'd17;
  localparam logic [4:0] S_SG5  = 5'd18;
  localparam logic [4:0] S_MS5  = 5'd19;
  localparam logic [4:0] S_W7   = 5'd20;
  localparam logic [4:0] S_TB7  = 5'd21;
  localparam logic [4:0] S_W8   = 5'd22;
  localparam logic [4:0] S_SG8  = 5'd23;
  localparam logic [4:0] S_MS8  = 5'd24;
  localparam logic [4:0] S_FIN  = 5'd25;

  logic [4:0] state;
  logic [4:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = 5'(state + 5'd1);
    cmd.op     = OP_NOP;
    case (state)
      S_IDLE: begin
        state_next = S_IDLE;
        if (in_valid) begin
          cmd.op = OP_ACC;
          if (status.complete) begin
            state_next = S_XZ;
          end
        end
      end
      S_XZ:  cmd.op = OP_M_XZ;
      S_HR:  cmd.op = OP_M_HR;
      S_TZ:  cmd.op = OP_T_Z;
      S_W1:  cmd.op = OP_M_W1;
      S_TT1: cmd.op = OP_T_T1;
      S_W6:  cmd.op = OP_M_W6;
      S_SG6: cmd.op = OP_SIG;
      S_MS6: cmd.op = OP_MUL_VS;
      S_W2:  cmd.op = OP_M_W2;
      S_TT2: cmd.op = OP_T_T2;
      S_W3:  cmd.op = OP_M_W3;
      S_LK3: cmd.op = OP_LK;
      S_LD3: cmd.op = OP_LK_L3;
      S_W4:  cmd.op = OP_M_W4;
      S_LK4: cmd.op = OP_LK;
      S_LD4: cmd.op = OP_LK_SUM;
      S_W5:  cmd.op = OP_M_W5;
      S_SG5: cmd.op = OP_SIG;
      S_MS5: cmd.op = OP_MUL_VS;
      S_W7:  cmd.op = OP_M_W7;
      S_TB7: cmd.op = OP_T_B7;
      S_W8:  cmd.op = OP_M_W8;
      S_SG8: cmd.op = OP_SIG;
      S_MS8: cmd.op = OP_MUL_VS;
      S_FIN: begin
        if (status.out_hold) begin
          state_next = S_FIN;
        end else begin
          cmd.op     = OP_FIN;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

/* src/ercf_dp.sv */
// datapath: config registers, accumulator, shared multiplier, activations, output register
// depends on ercf_pkg
`default_nettype none

module ercf_dp (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire ercf_pkg::ercf_cmd_t                       cmd,
  output ercf_pkg::ercf_status_t                         status,
  input  wire logic                                      cfg_write,
  input  wire logic [ercf_pkg::CfgIdxW-1:0]              cfg_index,
  input  wire logic [ercf_pkg::CfgDataW-1:0]             cfg_data,
  input  wire logic signed [ercf_pkg::DataW-1:0]         contribution,
  input  wire logic                                      first_step,
  output logic                                           out_valid,
  input  wire logic                                      out_stall,
  output logic signed [ercf_pkg::DataW-1:0]              hidden_out
);
  import ercf_pkg::*;

  logic [CntW-1:0] inputs_per_step;
  logic [63:0] weights_front;
  logic [63:0] weights_middle;
  logic [31:0] weights_back;
  logic [SlopeW-1:0] leaky_slope;

  logic signed [SumW-1:0] step_sum;
  logic [CntW-1:0] step_count;
  logic signed [DataW-1:0] previous_hidden;

  logic signed [SumW-1:0] x;
  logic signed [DataW-1:0] h;
  logic signed [PW-1:0] p;
  logic signed [PW-1:0] a;
  logic signed [TW-1:0] z;
  logic signed [TW-1:0] t1;
  logic signed [TW-1:0] t2;
  logic signed [LW-1:0] l3;
  logic signed [VW-1:0] v;
  logic [SW-1:0] s;
  logic signed [SumW-1:0] sum;

  logic signed [PW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [PW+BW-1:0] prod;
  logic mul_en;
  logic signed [SumW-1:0] acc_total;
  logic [CntW:0] count_inc;
  logic signed [VW-1:0] lk_val;
  logic signed [SumW:0] fin_total;
  logic signed [DataW-1:0] fin_sat;

  assign count_inc = {1'b0, step_count} + 9'd1;
  assign status.complete = (count_inc >= {1'b0, inputs_per_step});
  assign status.out_hold = out_valid && out_stall;
  assign acc_total = step_sum + SumW'(contribution);
  assign lk_val = v[VW-1] ? VW'(p) : v;
  assign fin_total = (SumW+1)'(sum) + (SumW+1)'(p);

  always_comb begin
    if (fin_total > 25'sd32767) begin
      fin_sat = 16'sh7fff;
    end else if (fin_total < -25'sd32768) begin
      fin_sat = -16'sh8000;
    end else begin
      fin_sat = DataW'(fin_total);
    end
  end

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (cmd.op)
      OP_M_XZ: begin
        mul_a = PW'(x);
        mul_b = BW'($signed(weights_front[15:0]));
      end
      OP_M_HR: begin
        mul_a = PW'(h);
        mul_b = BW'($signed(weights_front[31:16]));
      end
      OP_M_W1: begin
        mul_a = PW'(z);
        mul_b = BW'($signed(weights_front[47:32]));
      end
      OP_M_W2: begin
        mul_a = PW'(t1);
        mul_b = BW'($signed(weights_front[63:48]));
      end
      OP_M_W3: begin
        mul_a = PW'(t1);
        mul_b = BW'($signed(weights_middle[15:0]));
      end
      OP_M_W6: begin
        mul_a = PW'(t1);
        mul_b = BW'($signed(weights_middle[31:16]));
      end
      OP_M_W4: begin
        mul_a = PW'(t2);
        mul_b = BW'($signed(weights_middle[47:32]));
      end
      OP_M_W5: begin
        mul_a = PW'(l3);
        mul_b = BW'($signed(weights_middle[63:48]));
      end
      OP_M_W7: begin
        mul_a = PW'(l3);
        mul_b = BW'($signed(weights_back[15:0]));
      end
      OP_M_W8: begin
        mul_a = PW'(l3);
        mul_b = BW'($signed(weights_back[31:16]));
      end
      OP_MUL_VS: begin
        mul_a = PW'(v);
        mul_b = $signed({4'b0, s});
      end
      OP_LK: begin
        mul_a = p;
        mul_b = $signed({5'b0, leaky_slope});
      end
      default: mul_en = 1'b0;
    endcase
  end

  assign prod = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      inputs_per_step <= 8'd1;
      weights_front   <= '0;
      weights_middle  <= '0;
      weights_back    <= '0;
      leaky_slope     <= 12'd41;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IPS:   inputs_per_step <= cfg_data[CntW-1:0];
        REG_WF:    weights_front   <= cfg_data;
        REG_WM:    weights_middle  <= cfg_data;
        REG_WB:    weights_back    <= cfg_data[31:0];
        REG_SLOPE: leaky_slope     <= cfg_data[SlopeW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_sum        <= '0;
      step_count      <= '0;
      previous_hidden <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        OP_ACC: begin
          if (status.complete) begin
            step_sum   <= '0;
            step_count <= '0;
          end else begin
            step_sum   <= acc_total;
            step_count <= count_inc[CntW-1:0];
          end
        end
        OP_FIN: begin
          previous_hidden <= fin_sat;
          out_valid       <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      p <= prod[PW+11:12];
    end
    case (cmd.op)
      OP_ACC: begin
        x <= acc_total;
        h <= first_step ? '0 : previous_hidden;
      end
      OP_M_HR:   a <= p;
      OP_T_Z:    z <= act_tanh(ArgW'(a) + ArgW'(p));
      OP_T_T1:   t1 <= act_tanh(ArgW'(p));
      OP_T_T2:   t2 <= act_tanh(ArgW'(p));
      OP_SIG: begin
        v <= VW'(p);
        s <= sigmoid(ArgW'(p));
      end
      OP_LK:     v <= VW'(p);
      OP_LK_L3:  l3 <= LW'(lk_val);
      OP_M_W2:   sum <= SumW'(p);
      OP_LK_SUM: sum <= sum + SumW'(lk_val);
      OP_M_W7:   sum <= sum + SumW'(p);
      OP_T_B7:   sum <= sum + SumW'(act_tanh(ArgW'(p)));
      OP_FIN:    hidden_out <= fin_sat;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* src/evolved_recurrent_cell_forward.sv */
// top level of the recurrent cell forward pass: controller plus datapath
// depends on ercf_pkg, ercf_ctrl, ercf_dp
// a contribution that does not complete a step is accepted without stalling the input; a completing one
// stalls the input while the controller runs its 24 sequencer steps on one shared multiplier and then a
// finish step, which waits while the output is held; its hidden_out is registered when the finish step issues
// synchronous active-high reset restores register defaults and clears the step
`default_nettype none

module evolved_recurrent_cell_forward (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [ercf_pkg::DataW-1:0]   contribution,
  input  wire logic                                first_step,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [ercf_pkg::DataW-1:0]        hidden_out,
  input  wire logic                                cfg_write,
  input  wire logic [ercf_pkg::CfgIdxW-1:0]        cfg_index,
  input  wire logic [ercf_pkg::CfgDataW-1:0]       cfg_data
);
  import ercf_pkg::*;

  ercf_cmd_t    cmd;
  ercf_status_t status;

  ercf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  ercf_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .contribution (contribution),
    .first_step   (first_step),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .hidden_out   (hidden_out)
  );

endmodule

`default_nettype wire

/* src/ercf_checker.sv */
// port-level checks of the recurrent cell forward pass, bound to the top level
// depends on evolved_recurrent_cell_forward
`default_nettype none

module ercf_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] hidden_out
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(hidden_out))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a completed step");

  a_ready_after_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !in_stall)
    else $error("input still stalled after result");

endmodule

bind evolved_recurrent_cell_forward ercf_checker u_ercf_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .hidden_out (hidden_out)
);

`default_nettype wire

/* tb/testbench.sv */
// testbench for evolved_recurrent_cell_forward: directed table then random transfers,
// each hidden_out checked against a typed table value or an in-bench fixed-point model of the cell
// depends on ercf_pkg and the evolved_recurrent_cell_forward rtl
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ercf_pkg::*;

  localparam int StallLimit = 20000;
  localparam int Tail = 60;
  localparam logic [CfgIdxW-1:0] REG_NONE = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [DataW-1:0] contribution = '0;
  logic first_step = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [DataW-1:0] hidden_out;
  logic cfg_write = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  evolved_recurrent_cell_forward u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .contribution(contribution), .first_step(first_step),
    .out_valid(out_valid), .out_stall(out_stall), .hidden_out(hidden_out),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model state
  longint m_count_cfg, m_slope;
  logic [63:0] m_wf, m_wm;
  logic [31:0] m_wb;
  longint m_sum, m_count, m_hprev;
  logic signed [DataW-1:0] hidden_q[$];
  int errors = 0;
  int idle_cycles = 0;

  localparam longint TanhTab[11] = '{0, 1893, 3119, 3707, 3949, 4041, 4076, 4089,
                                     4093, 4095, 4096};

  function automatic longint fmul(longint a, longint b);
    longint p;
    p = a * b;
    return p >>> 12;
  endfunction

  function automatic longint wslot(logic [63:0] r, int s);
    return longint'($signed(r[16*s +: 16]));
  endfunction

  function automatic longint tmag(longint a);
    longint i, f;
    if (a >= 20480) return 4096;
    i = a >> 11;
    f = a & 2047;
    return TanhTab[i] + (((TanhTab[i+1] - TanhTab[i]) * f) >> 11);
  endfunction

  function automatic longint ftanh(longint v);
    return v < 0 ? -tmag(-v) : tmag(v);
  endfunction

  function automatic longint fswish(longint v);
    longint s;
    s = (4096 + tmag((v < 0 ? -v : v) >> 1)) >> 1;
    if (v < 0) s = 4096 - s;
    return fmul(v, s);
  endfunction

  function automatic longint fleaky(longint v);
    return v >= 0 ? v : fmul(v, m_slope);
  endfunction

  // returns 1 when the contribution completes a step
  function automatic bit cell_step(logic signed [DataW-1:0] c, bit first,
                                   output logic signed [DataW-1:0] h_new);
    longint h, z, t1, b6, t2, l3, b4, b5, b7, b8, s;
    h_new = '0;
    m_sum += longint'(c);
    m_count = (m_count + 1) & 255;
    if (m_count < m_count_cfg) return 1'b0;
    h = first ? 0 : m_hprev;
    z  = ftanh(fmul(m_sum, wslot(m_wf, 0)) + fmul(h, wslot(m_wf, 1)));
    m_sum = 0;
    m_count = 0;
    t1 = ftanh(fmul(wslot(m_wf, 2), z));
    b6 = fswish(fmul(wslot(m_wm, 1), t1));
    t2 = ftanh(fmul(wslot(m_wf, 3), t1));
    l3 = fleaky(fmul(wslot(m_wm, 0), t1));
    b4 = fleaky(fmul(wslot(m_wm, 2), t2));
    b5 = fswish(fmul(wslot(m_wm, 3), l3));
    b7 = ftanh(fmul(wslot({32'b0, m_wb}, 0), l3));
    b8 = fswish(fmul(wslot({32'b0, m_wb}, 1), l3));
    s = b6 + b4 + b5 + b7 + b8;
    if (s > 32767) s = 32767;
    if (s < -32768) s = -32768;
    m_hprev = s;
    h_new = DataW'(s);
    return 1'b1;
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [63:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_IPS:   m_count_cfg = (val[7:0] == 0) ? 1 : val[7:0];
      REG_WF:    m_wf = val;
      REG_WM:    m_wm = val;
      REG_WB:    m_wb = val[31:0];
      REG_SLOPE: m_slope = val[11:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // value typed in the directed table, or predictor checked when has_exp is 0
  typedef struct {
    logic signed [DataW-1:0] c;
    bit first;
    bit has_exp;
    logic signed [DataW-1:0] exp_h;
  } row_t;

  task automatic send(logic signed [DataW-1:0] c, bit first, bit has_exp,
                      logic signed [DataW-1:0] exp_h);
    logic signed [DataW-1:0] h;
    in_valid <= 1'b1;
    contribution <= c;
    first_step <= first;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (cell_step(c, first, h)) begin
      if (has_exp && h !== exp_h)
        $display("%0t table entry disagrees: table %0d model %0d", $time, exp_h, h);
      hidden_q.push_back(has_exp ? exp_h : h);
    end
    @(negedge clk);
  endtask

  task automatic send_gap(logic signed [DataW-1:0] c, bit first);
    send(c, first, 1'b0, '0);
    if ($urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (hidden_q.size() != 0) @(negedge clk);
    repeat (Tail) @(negedge clk);
  endtask

  function automatic logic [15:0] rnd_w;
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h1000;
      3: return 16'hf000;
      default: return 16'($urandom_range(0, 16'hffff));
    endcase
  endfunction

  function automatic logic signed [DataW-1:0] rnd_c;
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return -16'sh8000;
      2: return 16'($urandom_range(0, 16'hffff));
      default: return 16'(int'($urandom_range(0, 12000)) - 6000);
    endcase
  endfunction

  // receiver stalls in its own pattern
  always @(negedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 9) < 3);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (hidden_q.size() == 0) begin
        $display("%0t unexpected hidden_out: expected none actual %0d", $time, hidden_out);
        errors++;
      end else begin
        if (hidden_out !== hidden_q[0]) begin
          $display("%0t hidden_out mismatch: expected %0d actual %0d",
                   $time, hidden_q[0], hidden_out);
          errors++;
        end
        void'(hidden_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("FAIL evolved_recurrent_cell_forward");
      $finish;
    end
  end

  row_t dir_rows[$];

  initial begin
    m_count_cfg = 1; m_slope = 41; m_wf = '0; m_wm = '0; m_wb = '0;
    m_sum = 0; m_count = 0; m_hprev = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // all weights zero after reset: every step yields zero
    dir_rows = '{'{16'sh7fff, 1'b1, 1'b1, 16'sh0}, '{-16'sh8000, 1'b0, 1'b1, 16'sh0},
                 '{16'sh0001, 1'b0, 1'b1, 16'sh0}};
    foreach (dir_rows[i]) send(dir_rows[i].c, dir_rows[i].first, dir_rows[i].has_exp,
                               dir_rows[i].exp_h);
    drain();

    write_reg(REG_WF, {16'h1000, 16'h1000, 16'h7fff, 16'h7fff});
    write_reg(REG_WM, {16'h7fff, 16'h8000, 16'h7fff, 16'h8000});
    write_reg(REG_WB, {16'h7fff, 16'h8000});
    write_reg(REG_SLOPE, 64'd4095);
    write_reg(REG_NONE, 64'hffff_ffff_ffff_ffff);
    dir_rows = '{'{16'sh7fff, 1'b1, 1'b0, 16'sh0}, '{-16'sh8000, 1'b0, 1'b0, 16'sh0},
                 '{16'sh0800, 1'b0, 1'b0, 16'sh0}, '{-16'sh0800, 1'b1, 1'b0, 16'sh0},
                 '{16'sh0, 1'b0, 1'b0, 16'sh0}};
    foreach (dir_rows[i]) send(dir_rows[i].c, dir_rows[i].first, 1'b0, '0);
    drain();

    // zero count behaves as one, then lowering the count mid-step
    write_reg(REG_IPS, 64'd0);
    write_reg(REG_SLOPE, 64'd0);
    send(16'sh4000, 1'b0, 1'b0, '0);
    send(-16'sh4000, 1'b0, 1'b0, '0);
    drain();
    write_reg(REG_IPS, 64'd255);
    for (int i = 0; i < 255; i++) send(-16'sh8000, i == 254, 1'b0, '0);
    for (int i = 0; i < 5; i++) send(16'sh7fff, 1'b0, 1'b0, '0);
    drain();
    write_reg(REG_IPS, 64'd3);
    send(16'sh0100, 1'b0, 1'b0, '0);
    drain();

    // random phases
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(REG_IPS, 64'($urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                                       : $urandom_range(1, 6)));
      write_reg(REG_WF, {rnd_w(), rnd_w(), rnd_w(), rnd_w()});
      write_reg(REG_WM, {rnd_w(), rnd_w(), rnd_w(), rnd_w()});
      write_reg(REG_WB, {32'b0, rnd_w(), rnd_w()});
      write_reg(REG_SLOPE, 64'($urandom_range(0, 4095)));
      if (ph == 5) write_reg(REG_IPS, 64'd1);
      for (int i = 0; i < 86; i++) send_gap(rnd_c(), $urandom_range(0, 7) == 0);
      drain();
    end
    if (errors == 0) begin
      $display("PASS evolved_recurrent_cell_forward");
    end else begin
      $display("FAIL evolved_recurrent_cell_forward");
    end
    $finish;
  end

endmodule

`default_nettype wire
